[rtl/mks_pkg.sv]
// Package for the 4x4 matrix keypad scanner.
// Holds the configuration register map, reset values, key map and
// small helpers shared by the top level and its checker.
package mks_pkg;

  localparam int unsigned Rows = 4;
  localparam int unsigned Cols = 4;

  localparam int unsigned RowW      = $clog2(Rows);
  localparam int unsigned ColW      = $clog2(Cols);
  localparam int unsigned SettleW   = 10;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned CodeW     = 8;

  localparam logic [SettleW-1:0]   SettleReset   = 10'd10;
  localparam logic [DebounceW-1:0] DebounceReset = 16'd20000;
  localparam logic [CodeW-1:0]     NoKey         = 8'd255;
  localparam logic [CodeW-1:0]     MaxKey        = 8'd15;

  typedef enum logic {
    CFG_SETTLE   = 1'b0,
    CFG_DEBOUNCE = 1'b1
  } cfg_index_e;

  // Key map: row 0 = D # 0 *, row 1 = C 9 8 7, row 2 = B 6 5 4, row 3 = A 3 2 1
  function automatic logic [CodeW-1:0] key_lookup(input logic [RowW-1:0] row,
                                                  input logic [ColW-1:0] col);
    logic [CodeW-1:0] code;
    code = NoKey;
    unique case ({row, col})
      4'h0: code = 8'd13;
      4'h1: code = 8'd15;
      4'h2: code = 8'd0;
      4'h3: code = 8'd14;
      4'h4: code = 8'd12;
      4'h5: code = 8'd9;
      4'h6: code = 8'd8;
      4'h7: code = 8'd7;
      4'h8: code = 8'd11;
      4'h9: code = 8'd6;
      4'hA: code = 8'd5;
      4'hB: code = 8'd4;
      4'hC: code = 8'd10;
      4'hD: code = 8'd3;
      4'hE: code = 8'd2;
      4'hF: code = 8'd1;
      default: code = NoKey;
    endcase
    return code;
  endfunction

  // Index of the lowest set bit; zero when none is set
  function automatic logic [ColW-1:0] lowest_set(input logic [Cols-1:0] vec);
    logic [ColW-1:0] idx;
    idx = '0;
    for (int i = Cols - 1; i >= 0; i--) begin
      if (vec[i]) idx = ColW'(i);
    end
    return idx;
  endfunction

endpackage

[rtl/matrix_keypad_scanner_top.sv]
// Matrix keypad scanner top level: input register, scan state machine and
// result register. Depends on mks_pkg.
//
// Each request is one timer tick carrying the sampled active-low column
// levels; each tick yields exactly one result with the row drive of that
// tick, a key-valid flag and the key code (255 when no key). A request
// passes the input register and the scan logic into the result register;
// one request is taken every cycle while the result side keeps up, and the
// scan state advances by one step per tick. Settle and debounce lengths are
// counted in ticks.
module matrix_keypad_scanner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mks_pkg::DebounceW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mks_pkg::Cols-1:0]      column_levels_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mks_pkg::Rows-1:0]      row_drive_o,
  output logic                          key_valid_o,
  output logic [mks_pkg::CodeW-1:0]     key_code_o
);

  typedef enum logic [2:0] {
    PH_SETTLE       = 3'd0,
    PH_PRESS_DEB    = 3'd1,
    PH_RELEASE_WAIT = 3'd2,
    PH_RELEASE_DEB  = 3'd3
  } phase_e;

  logic [mks_pkg::SettleW-1:0]   settle_q;
  logic [mks_pkg::DebounceW-1:0] debounce_q;

  logic                       in_v_q;
  logic [mks_pkg::Cols-1:0]   cols_q;

  phase_e                        phase_q, phase_d;
  logic [mks_pkg::RowW-1:0]      row_q, row_d;
  logic [mks_pkg::DebounceW-1:0] timer_q, timer_d;
  logic [mks_pkg::ColW-1:0]      held_q, held_d;

  logic                       out_v_q;
  logic [mks_pkg::Rows-1:0]   row_drive_q, row_drive_d;
  logic                       key_valid_q, key_valid_d;
  logic [mks_pkg::CodeW-1:0]  key_code_q, key_code_d;

  logic                       advance;
  logic                       step;
  logic [mks_pkg::Cols-1:0]   low_cols;
  logic [mks_pkg::Cols-1:0]   rest_cols;
  logic [mks_pkg::ColW:0]     rest_start;
  logic                       held_low;
  logic [mks_pkg::DebounceW-1:0] timer_inc;

  assign advance    = !out_v_q || out_ready_i;
  assign step       = in_v_q && advance;
  assign in_ready_o = !in_v_q || advance;

  assign low_cols   = ~cols_q;
  assign rest_start = {1'b0, held_q} + 1'b1;
  assign rest_cols  = low_cols & (mks_pkg::Cols'({mks_pkg::Cols{1'b1}}) << rest_start);
  assign held_low   = low_cols[held_q];
  assign timer_inc  = timer_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    row_d       = row_q;
    timer_d     = timer_q;
    held_d      = held_q;
    row_drive_d = ~(mks_pkg::Rows'(1) << row_q);
    key_valid_d = 1'b0;
    key_code_d  = mks_pkg::NoKey;
    unique case (phase_q)
      PH_SETTLE: begin
        if (timer_q < {{(mks_pkg::DebounceW - mks_pkg::SettleW){1'b0}}, settle_q}) begin
          timer_d = timer_inc;
        end else if (low_cols != '0) begin
          held_d  = mks_pkg::lowest_set(low_cols);
          phase_d = PH_PRESS_DEB;
          timer_d = '0;
        end else begin
          row_d   = row_q + 1'b1;
          phase_d = PH_SETTLE;
          timer_d = '0;
          held_d  = '0;
        end
      end
      PH_PRESS_DEB, PH_RELEASE_DEB: begin
        if (timer_q < debounce_q) begin
          timer_d = timer_inc;
        end else if (phase_q == PH_PRESS_DEB && held_low) begin
          phase_d = PH_RELEASE_WAIT;
        end else begin
          if (phase_q == PH_RELEASE_DEB) begin
            key_valid_d = 1'b1;
            key_code_d  = mks_pkg::key_lookup(row_q, held_q);
          end
          if (rest_cols != '0) begin
            held_d  = mks_pkg::lowest_set(rest_cols);
            phase_d = PH_PRESS_DEB;
            timer_d = '0;
          end else begin
            row_d   = row_q + 1'b1;
            phase_d = PH_SETTLE;
            timer_d = '0;
            held_d  = '0;
          end
        end
      end
      PH_RELEASE_WAIT: begin
        if (!held_low) begin
          phase_d = PH_RELEASE_DEB;
          timer_d = '0;
        end
      end
      default: begin
        phase_d = PH_SETTLE;
        timer_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= mks_pkg::SettleReset;
      debounce_q <= mks_pkg::DebounceReset;
    end else if (cfg_we_i) begin
      unique case (mks_pkg::cfg_index_e'(cfg_index_i))
        mks_pkg::CFG_SETTLE:   settle_q   <= cfg_data_i[mks_pkg::SettleW-1:0];
        mks_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      phase_q <= PH_SETTLE;
      row_q   <= '0;
      timer_q <= '0;
      held_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (advance) begin
        out_v_q <= in_v_q;
      end
      if (step) begin
        phase_q <= phase_d;
        row_q   <= row_d;
        timer_q <= timer_d;
        held_q  <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cols_q <= column_levels_i;
    end
    if (step) begin
      row_drive_q <= row_drive_d;
      key_valid_q <= key_valid_d;
      key_code_q  <= key_code_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign row_drive_o = row_drive_q;
  assign key_valid_o = key_valid_q;
  assign key_code_o  = key_code_q;

endmodule

[rtl/mks_checker.sv]
// Port-level checker for the matrix keypad scanner, bound to the top level.
// Depends on mks_pkg and matrix_keypad_scanner_top.
module mks_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [mks_pkg::Rows-1:0]  row_drive_o,
  input logic                      key_valid_o,
  input logic [mks_pkg::CodeW-1:0] key_code_o
);

  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(~row_drive_o))
    else $error("row drive must have exactly one row low");

  a_no_key_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_valid_o) |-> (key_code_o == mks_pkg::NoKey))
    else $error("key code must be none without a key");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_valid_o) |-> (key_code_o <= mks_pkg::MaxKey))
    else $error("reported key code out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(row_drive_o) && $stable(key_valid_o) && $stable(key_code_o)))
    else $error("stalled result changed");

endmodule

bind matrix_keypad_scanner_top mks_checker u_mks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_drive_o (row_drive_o),
  .key_valid_o (key_valid_o),
  .key_code_o  (key_code_o)
);
